@@ hdl/mf1d_pkg.sv @@
// mf1d_pkg: shared constants for the 1-D morphology filter
// register indexes, widths, reset values and mode codes; no dependencies

package mf1d_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd1;

    // register widths and reset values
    localparam int WS_W   = 5;
    localparam int MODE_W = 2;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 5'd3;

    // filter mode codes
    localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRADIENT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RST = MODE_DILATE;

endpackage

@@ hdl/morphological_filter_1d_core.sv @@
// morphological_filter_1d_core: streaming 1-D dilation / erosion / gradient filter
// a sample is counted in pending_reg, then its result is registered in the output buffer
// throughput: one sample per cycle while the output buffer can load; a last word or a window shrink
//   holds samples back while the extra results drain (up to w+1 on last), one result per cycle when loadable
// reset: rst_n asynchronous active low; counters and valids cleared at once,
//   window size back to 3 and mode back to dilation

module morphological_filter_1d_core
    import mf1d_pkg::*;
#(
    parameter int MAX_WINDOW  = 31,
    parameter int SAMPLE_BITS = 16
)(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS:0]   value,
    output logic                          last_out
);

    // largest half window the shift line can serve
    localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
    // counters hold 0..HALF_MAX+1
    localparam int CNT_W = $clog2(HALF_MAX + 2);
    // tap offsets 0..MAX_WINDOW-1
    localparam int OFF_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int VAL_W = SAMPLE_BITS + 1;
    localparam logic [CNT_W-1:0] HALF_MAX_C = CNT_W'(HALF_MAX);

    // configuration registers
    logic [WS_W-1:0]   window_size_reg;
    logic [MODE_W-1:0] mode_reg;

    // word counters: results still owed for the current waveform, and the
    // output position saturated at HALF_MAX (saturated means no left clipping)
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;
    logic [CNT_W-1:0] next_pos_reg;
    logic [CNT_W-1:0] next_pos_next;
    logic             last_hold_reg;
    logic             last_hold_next;
    // half window taken with the latest accepted word; the words that word
    // releases are all sized by it
    logic [CNT_W-1:0] w_hold_reg;
    logic [CNT_W-1:0] w_hold_next;

    logic [WS_W-2:0]  w_raw;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] pend_m1;
    logic [CNT_W-1:0] left;
    logic [OFF_W-1:0] lo;
    logic [OFF_W-1:0] hi;
    logic             need;
    logic             need_after;
    logic             emit;
    logic             final_emit;
    logic             accept;
    logic             can_load;

    logic signed [VAL_W-1:0] win_value;
    logic [VAL_W:0]          out_word;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RST;
            mode_reg        <= MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WS_W-1:0];
                REG_MODE:        mode_reg        <= cfg_wdata[MODE_W-1:0];
                default:         ;
            endcase
        end
    end

    // half window, capped to what the shift line holds
    assign w_raw = window_size_reg[WS_W-1:1];
    assign w_eff = (32'(w_raw) > HALF_MAX) ? HALF_MAX_C : CNT_W'(w_raw);

    assign pend_m1 = pending_reg - CNT_W'(1);

    // a result is owed once w newer samples exist, or at once on a last word;
    // a new window size only takes effect with the next accepted word
    assign need       = (pending_reg != '0) && (last_hold_reg || (pending_reg > w_hold_reg));
    assign need_after = (pend_m1 != '0) && (last_hold_reg || (pend_m1 > w_hold_reg));
    assign emit       = need && can_load;
    assign final_emit = emit && last_hold_reg && (pend_m1 == '0);

    // the shift line may move only when no result is due, or when the word in flight is the last one due
    assign sample_ready = !need || (emit && !need_after);
    assign accept       = sample_valid && sample_ready;

    // window of the oldest owed position, as offsets from the newest tap:
    // right side clipped by the newest sample, left side by the waveform start
    assign left = (next_pos_reg < w_hold_reg) ? next_pos_reg : w_hold_reg;
    assign lo   = (pend_m1 > w_hold_reg) ? OFF_W'(pend_m1 - w_hold_reg) : '0;
    assign hi   = OFF_W'(pend_m1) + OFF_W'(left);

    always_comb
    begin
        pending_next = pending_reg - CNT_W'(emit) + CNT_W'(accept);

        w_hold_next = accept ? w_eff : w_hold_reg;

        next_pos_next = next_pos_reg;
        if (final_emit)
        begin
            next_pos_next = '0;
        end
        else if (emit && (next_pos_reg != HALF_MAX_C))
        begin
            next_pos_next = next_pos_reg + CNT_W'(1);
        end

        last_hold_next = last_hold_reg;
        if (accept)
        begin
            last_hold_next = last;
        end
        else if (final_emit)
        begin
            last_hold_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            next_pos_reg  <= '0;
            last_hold_reg <= 1'b0;
            w_hold_reg    <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            next_pos_reg  <= next_pos_next;
            last_hold_reg <= last_hold_next;
            w_hold_reg    <= w_hold_next;
        end
    end

    // shift line and compare tree
    mf1d_window #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk        (clk),
        .shift_en   (accept),
        .shift_data (sample),
        .lo         (lo),
        .hi         (hi),
        .mode       (mode_reg),
        .value      (win_value)
    );

    // result word: value and the end-of-waveform mark
    assign out_word = {win_value, final_emit};

    mf1d_out_buf #(
        .DATA_W (VAL_W + 1)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (out_word),
        .can_load  (can_load),
        .out_valid (result_valid),
        .out_data  ({value, last_out}),
        .out_ready (result_ready)
    );

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(HALF_MAX + 1))
        else $error("more results owed than the shift line can serve");

    a_accept_owes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pending_reg != '0))
        else $error("accepted word left nothing owed");

    a_last_owes: assert property (@(posedge clk) disable iff (!rst_n)
        last_hold_reg |-> (pending_reg != '0))
        else $error("last mark held with no result owed");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_pos_reg <= HALF_MAX_C)
        else $error("output position passed its saturation point");
`endif

endmodule

@@ hdl/mf1d_window.sv @@
// mf1d_window: sample shift line and masked max/min compare tree
// depends on mf1d_pkg for mode codes

module mf1d_window
    import mf1d_pkg::*;
#(
    parameter int MAX_WINDOW  = 31,
    parameter int SAMPLE_BITS = 16,
    localparam int OFF_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int VAL_W = SAMPLE_BITS + 1
)(
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] shift_data,
    input  logic [OFF_W-1:0]              lo,
    input  logic [OFF_W-1:0]              hi,
    input  logic [MODE_W-1:0]             mode,
    output logic signed [VAL_W-1:0]       value
);

    localparam int LEAVES = 1 << OFF_W;
    localparam logic [SAMPLE_BITS-1:0] NEG_MOST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] POS_MOST = ~NEG_MOST;

    // tap 0 is the newest sample
    logic signed [SAMPLE_BITS-1:0] tap_reg [MAX_WINDOW];

    logic signed [SAMPLE_BITS-1:0] mx_node [2*LEAVES-1];
    logic signed [SAMPLE_BITS-1:0] mn_node [2*LEAVES-1];
    logic signed [VAL_W-1:0]       mx_ext;
    logic signed [VAL_W-1:0]       mn_ext;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tap_reg[0] <= shift_data;
            for (int k = 1; k < MAX_WINDOW; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    // leaves outside lo..hi carry the identity of each reduction
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            mx_node[LEAVES-1+i] = $signed(NEG_MOST);
            mn_node[LEAVES-1+i] = $signed(POS_MOST);
        end
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if ((OFF_W'(i) >= lo) && (OFF_W'(i) <= hi))
            begin
                mx_node[LEAVES-1+i] = tap_reg[i];
                mn_node[LEAVES-1+i] = tap_reg[i];
            end
        end
        for (int i = LEAVES - 2; i >= 0; i--)
        begin
            mx_node[i] = (mx_node[2*i+1] > mx_node[2*i+2]) ? mx_node[2*i+1] : mx_node[2*i+2];
            mn_node[i] = (mn_node[2*i+1] < mn_node[2*i+2]) ? mn_node[2*i+1] : mn_node[2*i+2];
        end
    end

    assign mx_ext = {mx_node[0][SAMPLE_BITS-1], mx_node[0]};
    assign mn_ext = {mn_node[0][SAMPLE_BITS-1], mn_node[0]};

    always_comb
    begin
        case (mode)
            MODE_DILATE:   value = mx_ext;
            MODE_ERODE:    value = mn_ext;
            MODE_GRADIENT: value = mx_ext - mn_ext;
            default:       value = '0;
        endcase
    end

endmodule

@@ hdl/mf1d_out_buf.sv @@
// mf1d_out_buf: two-slot output register with skid slot
// no package dependency

module mf1d_out_buf #(
    parameter int DATA_W = 18
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] load_data,
    output logic              can_load,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data,
    input  logic              out_ready
);

    logic              main_v_reg;
    logic              main_v_next;
    logic              skid_v_reg;
    logic              skid_v_next;
    logic [DATA_W-1:0] main_d_reg;
    logic [DATA_W-1:0] skid_d_reg;
    logic              pop;
    logic              main_from_skid;
    logic              main_from_in;
    logic              skid_from_in;

    assign pop      = main_v_reg && out_ready;
    assign can_load = !skid_v_reg;

    always_comb
    begin
        main_v_next    = main_v_reg;
        skid_v_next    = skid_v_reg;
        main_from_skid = 1'b0;
        main_from_in   = 1'b0;
        skid_from_in   = 1'b0;
        if (pop)
        begin
            if (skid_v_reg)
            begin
                main_from_skid = 1'b1;
                skid_v_next    = 1'b0;
            end
            else
            begin
                main_v_next  = load;
                main_from_in = load;
            end
        end
        else if (main_v_reg)
        begin
            if (load)
            begin
                skid_from_in = 1'b1;
                skid_v_next  = 1'b1;
            end
        end
        else
        begin
            main_v_next  = load;
            main_from_in = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_from_skid)
        begin
            main_d_reg <= skid_d_reg;
        end
        else if (main_from_in)
        begin
            main_d_reg <= load_data;
        end
        if (skid_from_in)
        begin
            skid_d_reg <= load_data;
        end
    end

    assign out_valid = main_v_reg;
    assign out_data  = main_d_reg;

`ifndef SYNTHESIS
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid slot holds a word while the main slot is empty");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !skid_v_reg)
        else $error("word loaded while both slots are full");

    a_skid_refills_main: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && out_ready) |=> main_v_reg)
        else $error("skid word lost on pop");
`endif

endmodule

@@ tb/sv/morphological_filter_1d_core_checker.sv @@
// morphological_filter_1d_core_checker: scoreboard for the 1-D morphology filter core
// follows register writes, predicts the filtered words of each accepted sample, checks results
// depends on mf1d_pkg
`timescale 1ns / 1ps

module morphological_filter_1d_core_checker
    import mf1d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  logic signed [15:0]    sample,
    input  logic                  last,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  logic signed [16:0]    value,
    input  logic                  last_out,
    output int                    mismatches,
    output int                    outstanding,
    output int                    words_checked,
    output int                    samples_taken
);

    localparam int RING_DEPTH = 31;
    localparam int HALF_SPAN  = (RING_DEPTH - 1) / 2;
    localparam int MAX_BURST  = HALF_SPAN + 1;

    typedef struct packed {
        logic signed [16:0] value;
        logic               last_out;
    } filtered_word_t;

    filtered_word_t awaited_words[$];

    logic signed [15:0] history [RING_DEPTH];
    int                 write_slot;
    logic [15:0]        wave_count;
    logic [15:0]        emit_pos;
    logic               left_full;
    logic [WS_W-1:0]    win_size;
    logic [MODE_W-1:0]  filter_mode;

    task automatic note_mismatch(input string what);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // queue every word released by this sample, oldest position first
    task automatic filter_sample(input logic signed [15:0] s, input logic end_mark);
        int             span;
        int             newest;
        int             backlog;
        int             right_n;
        int             left_n;
        int             lo;
        int             hi;
        int             slot;
        int             peak;
        int             floor_v;
        int             burst;
        logic [15:0]    gap;
        filtered_word_t fw;
        begin
            span = int'(win_size) >> 1;
            if (span > HALF_SPAN)
                span = HALF_SPAN;
            newest = write_slot;
            history[newest] = s;
            write_slot = (write_slot + 1) % RING_DEPTH;
            wave_count = wave_count + 16'd1;
            gap = wave_count - emit_pos;
            backlog = int'(gap);
            burst = 0;
            while (backlog > 0 && (end_mark || backlog > span) && burst < MAX_BURST)
            begin
                right_n = (backlog - 1 < span) ? backlog - 1 : span;
                if (left_full)
                    left_n = span;
                else
                    left_n = (int'(emit_pos) < span) ? int'(emit_pos) : span;
                lo = backlog - 1 - right_n;
                hi = backlog - 1 + left_n;
                peak = 0;
                floor_v = 0;
                for (int off = lo; off <= hi; off++)
                begin
                    slot = (newest + RING_DEPTH - (off % RING_DEPTH)) % RING_DEPTH;
                    if (off == lo || history[slot] > peak)
                        peak = history[slot];
                    if (off == lo || history[slot] < floor_v)
                        floor_v = history[slot];
                end
                case (filter_mode)
                    MODE_DILATE:   fw.value = 17'(peak);
                    MODE_ERODE:    fw.value = 17'(floor_v);
                    MODE_GRADIENT: fw.value = 17'(peak - floor_v);
                    default:       fw.value = '0;
                endcase
                fw.last_out = end_mark && backlog == 1;
                awaited_words.insert(awaited_words.size(), fw);
                burst++;
                emit_pos = emit_pos + 16'd1;
                if (emit_pos >= HALF_SPAN)
                    left_full = 1'b1;
                backlog--;
            end
            if (end_mark)
            begin
                wave_count = '0;
                emit_pos = '0;
                left_full = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        filtered_word_t want;
        if (!rst_n)
        begin
            awaited_words.delete();
            for (int k = 0; k < RING_DEPTH; k++)
                history[k] = '0;
            write_slot = 0;
            wave_count = '0;
            emit_pos = '0;
            left_full = 1'b0;
            win_size = WINDOW_SIZE_RST;
            filter_mode = MODE_RST;
            mismatches = 0;
            words_checked = 0;
            samples_taken = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WINDOW_SIZE)
                    win_size = cfg_wdata[WS_W-1:0];
                else if (cfg_index == REG_MODE)
                    filter_mode = cfg_wdata[MODE_W-1:0];
            end
            if (sample_valid && sample_ready)
            begin
                filter_sample(sample, last);
                samples_taken++;
            end
            if (result_valid && result_ready)
            begin
                words_checked++;
                if (awaited_words.size() == 0)
                    note_mismatch($sformatf("unexpected word value %0d last_out %0b",
                                            value, last_out));
                else
                begin
                    want = awaited_words.pop_front();
                    if (want.value !== value || want.last_out !== last_out)
                        note_mismatch($sformatf(
                            "expected value %0d last_out %0b, got value %0d last_out %0b",
                            want.value, want.last_out, value, last_out));
                end
            end
        end
        outstanding = awaited_words.size();
    end

endmodule

@@ tb/sv/morphological_filter_1d_core_tb.sv @@
// morphological_filter_1d_core_tb: stimulus and verdict for the 1-D morphology filter core
// drives samples, register writes and result backpressure; checking lives in the checker
// depends on mf1d_pkg, morphological_filter_1d_core and morphological_filter_1d_core_checker
`timescale 1ns / 1ps

module morphological_filter_1d_core_tb
    import mf1d_pkg::*;
;

    // mode code the package leaves unassigned; the core answers with zero values
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_PHASE = 26;
    localparam int LONG_STALL     = 300;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    logic signed [15:0]     sample       = '0;
    logic                   last         = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic signed [16:0]     value;
    logic                   last_out;

    int mismatches;
    int outstanding;
    int words_checked;
    int samples_taken;

    // idle percentages for each side, set per phase
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    // long receiver hold-off requests, served by the receiver process
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;
    int waveforms_sent = 0;

    always #2 clk = ~clk;

    morphological_filter_1d_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .last_out     (last_out)
    );

    morphological_filter_1d_core_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .last          (last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .value         (value),
        .last_out      (last_out),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .samples_taken (samples_taken)
    );

    // receiver side: random stalls, or a long counted hold-off when asked for one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (stall_served != stall_requests)
        begin
            stall_served = stall_requests;
            stall_left = LONG_STALL - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #16_000_000;
        $display("morphological_filter_1d_core test failed");
        $finish;
    end

    // offer one sample word, with random idle cycles ahead of it;
    // entered and left at a falling edge, valid stays up for a following word
    task automatic send_word(input logic [15:0] s, input logic end_mark);
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                sample_valid <= 1'b0;
                @(negedge clk);
            end
            sample_valid <= 1'b1;
            sample <= s;
            last <= end_mark;
            @(posedge clk);
            while (!sample_ready)
                @(posedge clk);
            if (end_mark)
                waveforms_sent++;
            @(negedge clk);
        end
    endtask

    // drop valid, wait for every predicted word, then let the core settle
    task automatic wait_idle();
        begin
            sample_valid <= 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    // write both registers; unused upper bits of the mode word get random junk
    task automatic load_filter_setup(input logic [CFG_DATA_W-1:0] ws,
                                     input logic [MODE_W-1:0] m);
        logic [CFG_DATA_W-1:0] mode_word;
        begin
            mode_word = CFG_DATA_W'($urandom);
            mode_word[MODE_W-1:0] = m;
            cfg_we <= 1'b1;
            cfg_index <= REG_WINDOW_SIZE;
            cfg_wdata <= ws;
            @(negedge clk);
            cfg_index <= REG_MODE;
            cfg_wdata <= mode_word;
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // mostly uniform samples, with the range ends, zero and minus one now and then
    function automatic logic [15:0] pick_sample();
        logic [15:0] r;
        begin
            r = 16'($urandom);
            if ($urandom_range(99) < 15)
            begin
                case ($urandom_range(3))
                    0:       r = 16'h7FFF;
                    1:       r = 16'h8000;
                    2:       r = 16'h0000;
                    default: r = 16'hFFFF;
                endcase
            end
            return r;
        end
    endfunction

    initial
    begin
        int                    phase;
        int                    n;
        int                    wave_left;
        logic [CFG_DATA_W-1:0] ws;
        logic [MODE_W-1:0]     m;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup: window 3, dilation, range ends side by side
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'hFFFF, 1'b1);
        wait_idle();

        // window zero: each word is its own sample; one-sample waveform too
        load_filter_setup(5'd0, MODE_ERODE);
        send_word(16'h8000, 1'b1);
        send_word(16'h0005, 1'b0);
        send_word(16'hFFF9, 1'b1);
        wait_idle();

        // widest window, gradient hits its full 65535 span
        load_filter_setup(5'd31, MODE_GRADIENT);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h1234, 1'b1);
        wait_idle();

        // unassigned mode code: zero values, last_out still marked
        load_filter_setup(5'd2, MODE_UNUSED);
        send_word(16'h4000, 1'b0);
        send_word(16'hC000, 1'b0);
        send_word(16'h0FF0, 1'b0);
        send_word(16'hF00F, 1'b1);
        wait_idle();

        // window shrinks mid-waveform: the backlog beyond the new span comes out
        // with the next sample
        load_filter_setup(5'd9, MODE_DILATE);
        send_word(16'h0010, 1'b0);
        send_word(16'h0200, 1'b0);
        send_word(16'hFFF0, 1'b0);
        send_word(16'h3000, 1'b0);
        send_word(16'h8001, 1'b0);
        send_word(16'h0007, 1'b0);
        wait_idle();
        load_filter_setup(5'd1, MODE_DILATE);
        send_word(16'h0100, 1'b0);
        send_word(16'h7FFE, 1'b0);
        send_word(16'hFFFE, 1'b1);
        wait_idle();

        // random phases; waveforms run across phase edges, so setups change mid-waveform
        wave_left = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 70;
                    rx_idle_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 70;
                end
                default:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 9;
                end
            endcase
            case ($urandom_range(5))
                0:       ws = 5'd0;
                1:       ws = 5'd1;
                2:       ws = 5'd31;
                default: ws = CFG_DATA_W'($urandom_range(30, 2));
            endcase
            if ($urandom_range(9) == 0)
                m = MODE_UNUSED;
            else
                m = MODE_W'($urandom_range(2));
            load_filter_setup(ws, m);
            // receiver holds off while words keep coming, so the core backs up
            if (phase == 4)
                stall_requests++;
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (wave_left == 0)
                    wave_left = ($urandom_range(4) == 0) ? int'($urandom_range(40, 13))
                                                         : int'($urandom_range(12, 1));
                send_word(pick_sample(), wave_left == 1);
                wave_left--;
            end
            wait_idle();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (16) @(negedge clk);

        $display("fed %0d samples in %0d waveforms, directed corners then random setups",
                 samples_taken, waveforms_sent);
        $display("checked %0d filtered words: windows 0 to 31, every mode code, stalls",
                 words_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("morphological_filter_1d_core test passed");
        else
            $display("morphological_filter_1d_core test failed");
        $finish;
    end

endmodule
